// ===== rtl/liquid_height_grid_lookup_unit_defines.svh =====
// Assertion helpers used by the checker file.
`ifndef LIQUID_HEIGHT_GRID_LOOKUP_UNIT_DEFINES_SVH
`define LIQUID_HEIGHT_GRID_LOOKUP_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LHG_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LHG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lhg_pkg.sv =====
package lhg_pkg;

  // Input operation codes
  typedef enum logic [1:0] {
    OP_HEIGHT = 2'd0,
    OP_FLAG   = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  // Register map, byte address = 4 * index
  typedef enum logic [2:0] {
    REG_ENABLE  = 3'd0,
    REG_TILES_X = 3'd1,
    REG_TILES_Y = 3'd2,
    REG_CORNER_X = 3'd3,
    REG_CORNER_Y = 3'd4,
    REG_INV_TILE = 3'd5,
    REG_ENTRY   = 3'd6,
    REG_KIND    = 3'd7
  } reg_e;

  // Corner slots of a tile in the vertex store
  typedef enum logic [1:0] {
    SLOT_00 = 2'd0,
    SLOT_10 = 2'd1,
    SLOT_01 = 2'd2,
    SLOT_11 = 2'd3
  } slot_e;

  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 32;

  localparam logic [3:0]  FLAG_MASK      = 4'hF;
  localparam logic [15:0] INV_TILE_RESET = 16'd15729;

  typedef struct packed {
    logic [1:0]         operation;
    logic [11:0]        write_index;
    logic signed [23:0] height_value;
    logic [7:0]         flag_value;
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    logic signed [23:0] surface_height;
    logic [15:0]        entry_out;
    logic [7:0]         kind_out;
  } out_item_t;

  typedef struct packed {
    logic               liquid_enable;
    logic [5:0]         tiles_x;
    logic [5:0]         tiles_y;
    logic signed [23:0] corner_x;
    logic signed [23:0] corner_y;
    logic [15:0]        inverse_tile_size;
    logic [15:0]        liquid_entry;
    logic [7:0]         liquid_kind;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic  clr;
    logic  wr_height;
    logic  wr_flag;
    logic  capture;
    logic  mul;
    logic  idx;
    logic  rd_en;
    slot_e rd_slot;
    logic  cap_en;
    slot_e cap_slot;
    logic  interp;
    logic  accum;
    logic  load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic bound_miss;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/lhg_regs.sv =====
module lhg_regs
  import lhg_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  localparam cfg_t CFG_RESET = '{
    liquid_enable:     1'b0,
    tiles_x:           6'd0,
    tiles_y:           6'd0,
    corner_x:          24'sd0,
    corner_y:          24'sd0,
    inverse_tile_size: INV_TILE_RESET,
    liquid_entry:      16'd0,
    liquid_kind:       8'd0
  };

  cfg_t cfg_q;
  reg_e sel;
  logic wr_en;

  assign sel    = reg_e'(paddr[APB_AW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (wr_en) begin
      case (sel)
        REG_ENABLE:   cfg_q.liquid_enable     <= pwdata[0];
        REG_TILES_X:  cfg_q.tiles_x           <= pwdata[5:0];
        REG_TILES_Y:  cfg_q.tiles_y           <= pwdata[5:0];
        REG_CORNER_X: cfg_q.corner_x          <= pwdata[23:0];
        REG_CORNER_Y: cfg_q.corner_y          <= pwdata[23:0];
        REG_INV_TILE: cfg_q.inverse_tile_size <= pwdata[15:0];
        REG_ENTRY:    cfg_q.liquid_entry      <= pwdata[15:0];
        REG_KIND:     cfg_q.liquid_kind       <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (sel)
      REG_ENABLE:   prdata = APB_DW'(cfg_q.liquid_enable);
      REG_TILES_X:  prdata = APB_DW'(cfg_q.tiles_x);
      REG_TILES_Y:  prdata = APB_DW'(cfg_q.tiles_y);
      REG_CORNER_X: prdata = APB_DW'(unsigned'(cfg_q.corner_x));
      REG_CORNER_Y: prdata = APB_DW'(unsigned'(cfg_q.corner_y));
      REG_INV_TILE: prdata = APB_DW'(cfg_q.inverse_tile_size);
      REG_ENTRY:    prdata = APB_DW'(cfg_q.liquid_entry);
      REG_KIND:     prdata = APB_DW'(cfg_q.liquid_kind);
      default:      prdata = '0;
    endcase
  end

endmodule

// ===== rtl/lhg_ctrl.sv =====
module lhg_ctrl
  import lhg_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] op_i,
  output logic       in_stall_o,
  input  sts_t       sts_i,
  output cmd_t       cmd_o
);

  typedef enum logic [11:0] {
    ST_CLEAR = 12'b0000_0000_0001,
    ST_IDLE  = 12'b0000_0000_0010,
    ST_MUL   = 12'b0000_0000_0100,
    ST_IDX   = 12'b0000_0000_1000,
    ST_RD0   = 12'b0000_0001_0000,
    ST_RD1   = 12'b0000_0010_0000,
    ST_RD2   = 12'b0000_0100_0000,
    ST_RD3   = 12'b0000_1000_0000,
    ST_RD4   = 12'b0001_0000_0000,
    ST_INTP  = 12'b0010_0000_0000,
    ST_ACC   = 12'b0100_0000_0000,
    ST_LOAD  = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          if (op_i == OP_HEIGHT) cmd_o.wr_height = 1'b1;
          if (op_i == OP_FLAG) cmd_o.wr_flag = 1'b1;
          if (op_i == OP_QUERY) begin
            cmd_o.capture = 1'b1;
            state_d       = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_IDX;
      end
      ST_IDX: begin
        cmd_o.idx = 1'b1;
        state_d   = ST_RD0;
      end
      ST_RD0: begin
        if (sts_i.bound_miss) begin
          state_d = ST_LOAD;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_slot = SLOT_00;
          state_d       = ST_RD1;
        end
      end
      ST_RD1: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_slot  = SLOT_10;
        cmd_o.cap_en   = 1'b1;
        cmd_o.cap_slot = SLOT_00;
        state_d        = ST_RD2;
      end
      ST_RD2: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_slot  = SLOT_01;
        cmd_o.cap_en   = 1'b1;
        cmd_o.cap_slot = SLOT_10;
        state_d        = ST_RD3;
      end
      ST_RD3: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_slot  = SLOT_11;
        cmd_o.cap_en   = 1'b1;
        cmd_o.cap_slot = SLOT_01;
        state_d        = ST_RD4;
      end
      ST_RD4: begin
        cmd_o.cap_en   = 1'b1;
        cmd_o.cap_slot = SLOT_11;
        state_d        = ST_INTP;
      end
      ST_INTP: begin
        cmd_o.interp = 1'b1;
        state_d      = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.accum = 1'b1;
        state_d     = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/lhg_dp.sv =====
module lhg_dp
  import lhg_pkg::*;
#(
  parameter int unsigned GRID_TILES  = 63,
  parameter int unsigned STORE_DEPTH = 4096
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      cmd_i,
  output sts_t      sts_o,
  input  cfg_t      cfg_i,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam logic [16:0] DEPTH = 17'(STORE_DEPTH);
  localparam logic signed [51:0] ROUND_HALF = 52'sd8388608;
  localparam logic signed [27:0] Z_MAX = 28'sd8388607;
  localparam logic signed [27:0] Z_MIN = -28'sd8388608;

  // Stores
  logic [23:0] vmem [STORE_DEPTH];
  logic        fmem [STORE_DEPTH];   // one bit per tile: low flag nibble all set

  logic [AW-1:0] clr_q;
  logic          win;
  logic          flag_rd_q;
  logic [23:0]   vrd_q;

  // Query registers
  logic signed [23:0] px_q, py_q;
  logic signed [41:0] prodx_q, prody_q;
  logic [12:0]        tile_q, base_q;
  logic [6:0]         row_q;
  logic               bmiss_q;
  logic signed [23:0] h00_q, h10_q, h01_q, h11_q;
  logic signed [49:0] p1_q, p2_q;
  logic signed [51:0] acc_q;
  logic               out_valid_q;
  out_item_t          out_q;

  // Combinational
  logic [5:0]         nx, ny, txi, tyi;
  logic [6:0]         row_d;
  logic [11:0]        ty_nx;
  logic [12:0]        ty_row;
  logic               bmiss_d;
  logic signed [24:0] dx, dy;
  logic signed [16:0] inv_s;
  logic [12:0]        a00, a10, a01, a11, rd_addr;
  logic               ok00, ok10, ok01, ok11, cap_ok, tile_ok;
  logic [23:0]        fx, fy;
  logic               lower;
  logic signed [24:0] fx_s, fy_s, d1, d2;
  logic signed [27:0] z;
  logic signed [23:0] z_sat;
  logic               masked;

  assign win = {5'b0, in_data_i.write_index} < DEPTH;

  // Clearing pass over the flag store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  assign sts_o.clr_last = (clr_q == AW'(STORE_DEPTH - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      fmem[clr_q] <= 1'b0;
    end else if (cmd_i.wr_flag && win) begin
      fmem[AW'(in_data_i.write_index)] <= (in_data_i.flag_value[3:0] == FLAG_MASK);
    end
    if (cmd_i.rd_en && cmd_i.rd_slot == SLOT_00) begin
      flag_rd_q <= fmem[AW'(tile_q)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_height && win) begin
      vmem[AW'(in_data_i.write_index)] <= in_data_i.height_value;
    end
    if (cmd_i.rd_en) begin
      vrd_q <= vmem[AW'(rd_addr)];
    end
  end

  // Tile coordinate: (point - corner) * reciprocal, Q.24
  assign dx    = 25'(px_q) - 25'(cfg_i.corner_x);
  assign dy    = 25'(py_q) - 25'(cfg_i.corner_y);
  assign inv_s = $signed({1'b0, cfg_i.inverse_tile_size});

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      px_q <= in_data_i.point_x;
      py_q <= in_data_i.point_y;
    end
    if (cmd_i.mul) begin
      prodx_q <= dx * inv_s;
      prody_q <= dy * inv_s;
    end
  end

  // Bounds and store indexes
  assign nx = ({2'b0, cfg_i.tiles_x} > 8'(GRID_TILES)) ? 6'(GRID_TILES) : cfg_i.tiles_x;
  assign ny = ({2'b0, cfg_i.tiles_y} > 8'(GRID_TILES)) ? 6'(GRID_TILES) : cfg_i.tiles_y;
  assign txi   = prodx_q[29:24];
  assign tyi   = prody_q[29:24];
  assign row_d = {1'b0, nx} + 7'd1;
  assign ty_nx  = 12'(tyi) * 12'(nx);
  assign ty_row = 13'(tyi) * 13'(row_d);

  assign bmiss_d = !cfg_i.liquid_enable || (nx == '0) || (ny == '0) ||
                   prodx_q[41] || prody_q[41] ||
                   (prodx_q[40:24] >= {11'b0, nx}) ||
                   (prody_q[40:24] >= {11'b0, ny});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bmiss_q <= 1'b1;
    end else if (cmd_i.idx) begin
      bmiss_q <= bmiss_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.idx) begin
      tile_q <= 13'(ty_nx) + 13'(txi);
      base_q <= ty_row + 13'(txi);
      row_q  <= row_d;
    end
  end

  assign sts_o.bound_miss = bmiss_q;

  // Four corner addresses; an address past the store reads as zero
  assign a00 = base_q;
  assign a10 = base_q + 13'd1;
  assign a01 = base_q + 13'(row_q);
  assign a11 = a01 + 13'd1;
  assign ok00 = {4'b0, a00} < DEPTH;
  assign ok10 = {4'b0, a10} < DEPTH;
  assign ok01 = {4'b0, a01} < DEPTH;
  assign ok11 = {4'b0, a11} < DEPTH;
  assign tile_ok = {4'b0, tile_q} < DEPTH;

  always_comb begin
    case (cmd_i.rd_slot)
      SLOT_00: rd_addr = a00;
      SLOT_10: rd_addr = a10;
      SLOT_01: rd_addr = a01;
      SLOT_11: rd_addr = a11;
      default: rd_addr = a00;
    endcase
  end

  always_comb begin
    case (cmd_i.cap_slot)
      SLOT_00: cap_ok = ok00;
      SLOT_10: cap_ok = ok10;
      SLOT_01: cap_ok = ok01;
      SLOT_11: cap_ok = ok11;
      default: cap_ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_en) begin
      case (cmd_i.cap_slot)
        SLOT_00: h00_q <= cap_ok ? vrd_q : '0;
        SLOT_10: h10_q <= cap_ok ? vrd_q : '0;
        SLOT_01: h01_q <= cap_ok ? vrd_q : '0;
        SLOT_11: h11_q <= cap_ok ? vrd_q : '0;
        default: ;
      endcase
    end
  end

  // Triangle interpolation
  assign fx    = prodx_q[23:0];
  assign fy    = prody_q[23:0];
  assign lower = fx > fy;
  assign fx_s  = $signed({1'b0, fx});
  assign fy_s  = $signed({1'b0, fy});
  assign d1 = lower ? (25'(h10_q) - 25'(h00_q)) : (25'(h11_q) - 25'(h01_q));
  assign d2 = lower ? (25'(h11_q) - 25'(h10_q)) : (25'(h01_q) - 25'(h00_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.interp) begin
      p1_q <= fx_s * d1;
      p2_q <= fy_s * d2;
    end
    if (cmd_i.accum) begin
      acc_q <= 52'(p1_q) + 52'(p2_q) + (52'(h00_q) <<< 24) + ROUND_HALF;
    end
  end

  // Round (bias already added), floor, saturate
  assign z = $signed(acc_q[51:24]);
  always_comb begin
    if (z > Z_MAX) begin
      z_sat = Z_MAX[23:0];
    end else if (z < Z_MIN) begin
      z_sat = Z_MIN[23:0];
    end else begin
      z_sat = z[23:0];
    end
  end

  assign masked = tile_ok && flag_rd_q;

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      if (bmiss_q || masked) begin
        out_q <= '0;
      end else begin
        out_q.hit            <= 1'b1;
        out_q.surface_height <= z_sat;
        out_q.entry_out      <= cfg_i.liquid_entry;
        out_q.kind_out       <= cfg_i.liquid_kind;
      end
    end
  end

  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

endmodule

// ===== rtl/liquid_height_grid_lookup_unit.sv =====
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  in_item_t (write height, write flag, query)
// out      output     out_valid / out_stall out_item_t (hit, height, entry, kind)
// cfg      input      APB psel/penable     8 registers at byte address 4*index
//
// A write is taken without leaving idle. A query holds the input from capture up to the
// result load (an early miss on disabled, empty grid or point outside skips the corner reads
// and arithmetic), as the single-port vertex store is read four times in series; the next
// item is taken the cycle after. After reset the flag store is cleared one entry a cycle,
// with in_stall high throughout. Configuration writes are taken at any time.
// A stalled result waits in the output register; the input stays open meanwhile.
module liquid_height_grid_lookup_unit
  import lhg_pkg::*;
#(
  parameter int unsigned GRID_TILES  = 63,
  parameter int unsigned STORE_DEPTH = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input transactions
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_data_i,
  // result transactions
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_data_o,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  // Register file
  lhg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequencer: clear pass, then one transaction at a time; a query walks multiply,
  // index, four corner reads, interpolate, accumulate, load; a miss skips to load.
  lhg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (in_data_i.operation),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Stores, arithmetic and output register
  lhg_dp #(
    .GRID_TILES  (GRID_TILES),
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_i       (cfg),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/lhg_checker.sv =====
`include "liquid_height_grid_lookup_unit_defines.svh"

module lhg_checker
  import lhg_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  `LHG_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")
  `LHG_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_data_o), "stalled result changed")
  `LHG_ASSERT_NOW(a_miss_zero, clk_i, rst_ni, out_valid_o && !out_data_o.hit, out_data_o.surface_height == '0 && out_data_o.entry_out == '0 && out_data_o.kind_out == '0, "miss carries nonzero fields")
  `LHG_ASSERT_NEXT(a_query_busy, clk_i, rst_ni, in_valid_i && !in_stall_o && in_data_i.operation == OP_QUERY, in_stall_o, "input open right after a query")
  `LHG_ASSERT_NEXT(a_write_silent, clk_i, rst_ni, in_valid_i && !in_stall_o && in_data_i.operation != OP_QUERY && !out_valid_o, !out_valid_o, "write produced a result")

endmodule

bind liquid_height_grid_lookup_unit lhg_checker u_lhg_checker (.*);

// ===== tb/sv/liquid_height_grid_lookup_unit_tb.sv =====
module liquid_height_grid_lookup_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lhg_pkg::*;

  // Operation code 3 is not decoded by the block; it must be dropped silently.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Cycles to let pass once the last result is in, before touching a register
  // or ending the run.
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned PHASE_ITEMS   = 165;

  // One row of the directed sequence: a register write or an input transaction,
  // with an optional hand-written result for rows whose answer is obvious.
  typedef struct {
    bit          is_reg;
    reg_e        addr;
    logic [31:0] data;
    in_item_t    item;
    bit          typed;
    out_item_t   want;
  } step_t;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_item   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_item;
  logic                 psel      = 1'b0;
  logic                 penable   = 1'b0;
  logic                 pwrite    = 1'b0;
  logic [APB_AW-1:0]    paddr     = '0;
  logic [APB_DW-1:0]    pwdata    = '0;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  // Shadow copy of the block: registers, vertex heights and tile flags.
  cfg_t                 mirror;
  logic signed [23:0]   heights [4096];
  bit                   vertex_set [4096];
  logic [7:0]           tile_flags [4096] = '{default: 8'h00};

  out_item_t            pending_surfaces [$];
  out_item_t            head;
  step_t                plan [$];

  int unsigned          snd_idle = 0;
  int unsigned          rcv_idle = 0;
  int unsigned          items_in = 0;
  int unsigned          reg_writes = 0;
  int unsigned          surfaces_seen = 0;
  int unsigned          hits_seen = 0;
  int unsigned          errors = 0;
  int unsigned          goal = 0;

  liquid_height_grid_lookup_unit DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #10ms;
    $display("liquid_height_grid_lookup_unit_tb: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Queue helpers
  // ---------------------------------------------------------------------------

  function automatic void add_row(step_t s);
    plan.insert(plan.size(), s);
  endfunction

  function automatic void queue_result(out_item_t r);
    pending_surfaces.insert(pending_surfaces.size(), r);
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Maps a point to its tile under the current registers. Returns 0 for every
  // early miss: liquid off, no tiles, negative tile coordinate, outside grid.
  function automatic bit find_tile(input logic signed [23:0] px, py,
                                   output int tx, ty, output longint fx, fy);
    longint qx, qy, nx, ny;
    nx = mirror.tiles_x;
    ny = mirror.tiles_y;
    tx = 0;
    ty = 0;
    fx = 0;
    fy = 0;
    if (!mirror.liquid_enable || nx == 0 || ny == 0) return 1'b0;
    // Q16.8 offset times Q0.16 reciprocal: tile in the upper bits, Q0.24 fraction below
    qx = (longint'(px) - longint'($signed(mirror.corner_x)))
         * longint'(mirror.inverse_tile_size);
    qy = (longint'(py) - longint'($signed(mirror.corner_y)))
         * longint'(mirror.inverse_tile_size);
    if (qx < 0 || qy < 0) return 1'b0;
    tx = int'(qx >>> 24);
    ty = int'(qy >>> 24);
    if (tx >= nx || ty >= ny) return 1'b0;
    fx = qx & 64'hFF_FFFF;
    fy = qy & 64'hFF_FFFF;
    return 1'b1;
  endfunction

  function automatic out_item_t surface_at(logic signed [23:0] px, py);
    out_item_t r;
    int        tx, ty, row;
    longint    fx, fy, h00, h10, h01, h11, acc, z;
    r = '0;
    if (!find_tile(px, py, tx, ty, fx, fy)) return r;
    // all four low flag bits set: tile has no liquid
    if (tile_flags[tx + ty * mirror.tiles_x][3:0] == FLAG_MASK) return r;
    row = mirror.tiles_x + 1;
    h00 = heights[tx + ty * row];
    h10 = heights[tx + 1 + ty * row];
    h01 = heights[tx + (ty + 1) * row];
    h11 = heights[tx + 1 + (ty + 1) * row];
    if (fx > fy)  // lower triangle
      acc = fx * (h10 - h00) + fy * (h11 - h10);
    else          // upper triangle, diagonal included
      acc = fx * (h11 - h01) + fy * (h01 - h00);
    // exact in Q.24, round half up, floor back to Q16.8
    z = (acc + (h00 <<< 24) + 64'sd8388608) >>> 24;
    if (z > 64'sd8388607) z = 64'sd8388607;
    if (z < -64'sd8388608) z = -64'sd8388608;
    r.hit            = 1'b1;
    r.surface_height = z[23:0];
    r.entry_out      = mirror.liquid_entry;
    r.kind_out       = mirror.liquid_kind;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Sends one input transaction and updates the shadow state when it is taken.
  task automatic push_item(in_item_t it, bit typed = 1'b0, out_item_t want = '0);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    case (it.operation)
      OP_HEIGHT: begin
        heights[it.write_index]    = it.height_value;
        vertex_set[it.write_index] = 1'b1;
      end
      OP_FLAG:  tile_flags[it.write_index] = it.flag_value;
      OP_QUERY: queue_result(typed ? want : surface_at(it.point_x, it.point_y));
      default: ;
    endcase
    if (it.operation != OP_UNUSED) items_in++;
  endtask

  // Heights are undefined until written, so any vertex a query would read gets
  // a random height first.
  task automatic cover_vertices(logic signed [23:0] px, py);
    int       tx, ty, row;
    int       corner_idx [4];
    longint   fx, fy;
    in_item_t it;
    if (!find_tile(px, py, tx, ty, fx, fy)) return;
    row = mirror.tiles_x + 1;
    corner_idx = '{tx + ty * row, tx + 1 + ty * row,
                   tx + (ty + 1) * row, tx + 1 + (ty + 1) * row};
    foreach (corner_idx[k]) begin
      if (!vertex_set[corner_idx[k]]) begin
        it              = '0;
        it.operation    = OP_HEIGHT;
        it.write_index  = 12'(corner_idx[k]);
        it.height_value = 24'($urandom);
        push_item(it);
      end
    end
  endtask

  // Drop valid, wait for every result, then let the pipeline run dry.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_surfaces.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, access cycle, taken when pready is high.
  task automatic set_reg(reg_e r, logic [31:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (r)
      REG_ENABLE:   mirror.liquid_enable     = v[0];
      REG_TILES_X:  mirror.tiles_x           = v[5:0];
      REG_TILES_Y:  mirror.tiles_y           = v[5:0];
      REG_CORNER_X: mirror.corner_x          = v[23:0];
      REG_CORNER_Y: mirror.corner_y          = v[23:0];
      REG_INV_TILE: mirror.inverse_tile_size = v[15:0];
      REG_ENTRY:    mirror.liquid_entry      = v[15:0];
      REG_KIND:     mirror.liquid_kind       = v[7:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic step_t reg_row(reg_e r, int v);
    step_t s;
    s.is_reg = 1'b1;
    s.addr   = r;
    s.data   = v;
    s.item   = '0;
    s.typed  = 1'b0;
    s.want   = '0;
    return s;
  endfunction

  function automatic step_t item_row(logic [1:0] op, int idx, int hv, int fv, int px, int py);
    step_t s;
    s.is_reg                 = 1'b0;
    s.addr                   = REG_ENABLE;
    s.data                   = '0;
    s.item.operation         = op;
    s.item.write_index       = 12'(idx);
    s.item.height_value      = 24'(hv);
    s.item.flag_value        = 8'(fv);
    s.item.point_x           = 24'(px);
    s.item.point_y           = 24'(py);
    s.typed                  = 1'b0;
    s.want                   = '0;
    return s;
  endfunction

  function automatic step_t with_answer(step_t s, bit h, int z, int e, int k);
    s.typed               = 1'b1;
    s.want.hit            = h;
    s.want.surface_height = 24'(z);
    s.want.entry_out      = 16'(e);
    s.want.kind_out       = 8'(k);
    return s;
  endfunction

  // Random coordinate that usually lands inside an n-tile span from base.
  function automatic logic signed [23:0] aim(logic signed [23:0] base, int n);
    longint span, p;
    if (mirror.inverse_tile_size == 0 || n == 0) return 24'($urandom);
    span = ((longint'(n) << 24) - 1) / longint'(mirror.inverse_tile_size);
    p = longint'(base) + longint'($urandom_range(32'(span)));
    if (p > 64'sd8388607) p = 64'sd8388607;
    return p[23:0];
  endfunction

  // One random transaction. Mostly queries aimed into the grid plus writes
  // into the live part of the stores; the rest is noise over the full ranges.
  task automatic send_random();
    logic [95:0] noise;
    in_item_t    it;
    int          nx, ny, nt, pick;
    noise = {$urandom, $urandom, $urandom};
    it    = noise[93:0];
    nx    = mirror.tiles_x;
    ny    = mirror.tiles_y;
    nt    = nx * ny;
    pick  = $urandom_range(99);
    if (pick < 45) begin
      it.operation = OP_QUERY;
      if ($urandom_range(4) != 0) begin
        it.point_x = aim(mirror.corner_x, nx);
        it.point_y = aim(mirror.corner_y, ny);
      end
      cover_vertices(it.point_x, it.point_y);
    end else if (pick < 70) begin
      it.operation = OP_HEIGHT;
      if ($urandom_range(1))
        it.write_index = 12'($urandom_range(nx) + $urandom_range(ny) * (nx + 1));
    end else if (pick < 90) begin
      it.operation = OP_FLAG;
      if (nt > 0 && $urandom_range(3) != 0) it.write_index = 12'($urandom_range(nt - 1));
      // bias toward masking values so masked tiles come up often
      if ($urandom_range(2) == 0) it.flag_value[3:0] = FLAG_MASK;
    end else begin
      it.operation = OP_UNUSED;
    end
    push_item(it);
  endtask

  // Writes all eight registers for one random phase. Extremes of every
  // register show up across the phases, though not every extreme of every one.
  task automatic load_phase(int p);
    logic [31:0] v [8];
    for (int k = 0; k < 8; k++) v[k] = $urandom;
    v[REG_ENABLE]   = 32'd1;
    v[REG_TILES_X]  = $urandom_range(63, 1);
    v[REG_TILES_Y]  = $urandom_range(63, 1);
    v[REG_CORNER_X] = int'($urandom_range(2097152)) - 1048576;
    v[REG_CORNER_Y] = int'($urandom_range(2097152)) - 1048576;
    v[REG_INV_TILE] = $urandom_range(65535, 4096);
    case (p)
      0: begin  // largest grid from the most negative corner
        v[REG_TILES_X]  = 63;
        v[REG_TILES_Y]  = 63;
        v[REG_CORNER_X] = -8388608;
        v[REG_CORNER_Y] = -8388608;
        v[REG_INV_TILE] = $urandom_range(65535, 1024);
        v[REG_ENTRY]    = 16'hFFFF;
        v[REG_KIND]     = 8'hFF;
      end
      1: begin  // single tile pinned at the top of x, bottom of y
        v[REG_TILES_X]  = 1;
        v[REG_TILES_Y]  = 1;
        v[REG_CORNER_X] = 8388607;
        v[REG_CORNER_Y] = -8388608;
        v[REG_INV_TILE] = 65535;
        v[REG_ENTRY]    = 0;
        v[REG_KIND]     = 0;
      end
      3: v[REG_ENABLE] = 32'd0;        // liquid off: everything misses
      4: begin                         // empty along x
        v[REG_TILES_X] = 0;
        v[REG_TILES_Y] = 63;
      end
      5: begin                         // zero reciprocal: all points fold onto tile 0
        v[REG_TILES_X]  = $urandom_range(8, 1);
        v[REG_TILES_Y]  = $urandom_range(8, 1);
        v[REG_CORNER_X] = $urandom;
        v[REG_CORNER_Y] = $urandom;
        v[REG_INV_TILE] = 0;
      end
      default: ;
    endcase
    settle();
    for (int k = 0; k < 8; k++) set_reg(reg_e'(k), v[k]);
  endtask

  task automatic report(string field, longint want, longint got);
    errors++;
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and result check
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rcv_idle);
  end

  // A result transaction is taken at a rising edge with valid high and stall low.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      surfaces_seen++;
      if (out_item.hit) hits_seen++;
      if (pending_surfaces.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, expected nothing, got %p", $time, out_item);
      end else begin
        head = pending_surfaces.pop_front();
        if (out_item.hit !== head.hit) report("hit", head.hit, out_item.hit);
        if (out_item.surface_height !== head.surface_height)
          report("surface_height", head.surface_height, out_item.surface_height);
        if (out_item.entry_out !== head.entry_out)
          report("entry_out", head.entry_out, out_item.entry_out);
        if (out_item.kind_out !== head.kind_out)
          report("kind_out", head.kind_out, out_item.kind_out);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    mirror                   = '0;
    mirror.inverse_tile_size = INV_TILE_RESET;

    // Directed rows. Tile size 4.0 (reciprocal 16384) puts tile edges at
    // multiples of 1024 in Q16.8, so expected tiles are easy to read off.
    add_row(with_answer(item_row(OP_QUERY, 0, 0, 0, 0, 0), 0, 0, 0, 0)); // liquid off
    add_row(reg_row(REG_ENABLE, 1));
    add_row(with_answer(item_row(OP_QUERY, 0, 0, 0, 0, 0), 0, 0, 0, 0)); // no tiles
    add_row(reg_row(REG_TILES_X, 2));
    add_row(reg_row(REG_TILES_Y, 2));
    add_row(reg_row(REG_CORNER_X, 0));
    add_row(reg_row(REG_CORNER_Y, 0));
    add_row(reg_row(REG_INV_TILE, 16384));
    add_row(reg_row(REG_ENTRY, 16'hFFFF));
    add_row(reg_row(REG_KIND, 8'hFF));
    add_row(item_row(OP_HEIGHT, 0, 8388607, 0, 0, 0));    // highest height
    add_row(item_row(OP_HEIGHT, 1, -8388608, 0, 0, 0));   // lowest height
    // grid corner itself: zero fraction returns the corner vertex unchanged
    add_row(with_answer(item_row(OP_QUERY, 0, 0, 0, 0, 0), 1, 8388607, 16'hFFFF, 8'hFF));
    add_row(item_row(OP_QUERY, 0, 0, 0, 512, 256));       // lower triangle
    add_row(item_row(OP_QUERY, 0, 0, 0, 256, 512));       // upper triangle
    add_row(item_row(OP_QUERY, 0, 0, 0, 300, 300));       // on the diagonal
    add_row(with_answer(item_row(OP_QUERY, 0, 0, 0, -1, 0), 0, 0, 0, 0));
    add_row(with_answer(item_row(OP_QUERY, 0, 0, 0, 0, -8388608), 0, 0, 0, 0));
    add_row(with_answer(item_row(OP_QUERY, 0, 0, 0, 2048, 0), 0, 0, 0, 0)); // past edge
    add_row(with_answer(item_row(OP_QUERY, 0, 0, 0, 8388607, 8388607), 0, 0, 0, 0));
    add_row(item_row(OP_QUERY, 0, 0, 0, 2047, 2047));     // last tile, top fraction
    add_row(item_row(OP_FLAG, 0, 0, 8'h0F, 0, 0));        // masks tile 0
    add_row(with_answer(item_row(OP_QUERY, 0, 0, 0, 100, 100), 0, 0, 0, 0));
    add_row(item_row(OP_FLAG, 0, 0, 8'hF7, 0, 0));        // one low bit clear
    add_row(item_row(OP_QUERY, 0, 0, 0, 100, 100));
    add_row(item_row(OP_FLAG, 0, 0, 8'hFF, 0, 0));
    add_row(with_answer(item_row(OP_QUERY, 0, 0, 0, 100, 100), 0, 0, 0, 0));
    add_row(item_row(OP_FLAG, 0, 0, 8'h00, 0, 0));
    add_row(item_row(OP_UNUSED, 4095, -1, 8'hFF, -1, -1)); // dropped, no result
    add_row(item_row(OP_HEIGHT, 4095, 24'h123456, 0, 0, 0));
    add_row(item_row(OP_FLAG, 4095, 0, 8'hFF, 0, 0));
    add_row(reg_row(REG_INV_TILE, 0));
    // zero reciprocal: even a point far below the corner folds onto tile 0
    add_row(with_answer(item_row(OP_QUERY, 0, 0, 0, -8388608, 8388607),
                        1, 8388607, 16'hFFFF, 8'hFF));

    // Directed part runs with the first idle mix.
    snd_idle = 35;
    rcv_idle = 76;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        settle();
        set_reg(plan[i].addr, plan[i].data);
      end else begin
        if (plan[i].item.operation == OP_QUERY)
          cover_vertices(plan[i].item.point_x, plan[i].item.point_y);
        push_item(plan[i].item, plan[i].typed, plan[i].want);
      end
    end

    // Random part: six register settings, idle mix changes every two phases.
    for (int p = 0; p < 6; p++) begin
      case (p / 2)
        0: begin snd_idle = 35; rcv_idle = 76; end
        1: begin snd_idle = 76; rcv_idle = 35; end
        default: begin snd_idle = 0; rcv_idle = 0; end
      endcase
      load_phase(p);
      goal = items_in + PHASE_ITEMS;
      while (items_in < goal) send_random();
    end

    settle();

    $display("%0d input transactions, %0d register writes, %0d results checked (%0d hits)",
             items_in, reg_writes, surfaces_seen, hits_seen);
    $display("register setups covered: liquid off, empty grid, zero reciprocal, corner and size extremes");
    if (errors == 0) begin
      $display("liquid_height_grid_lookup_unit_tb: clean");
    end else begin
      $display("liquid_height_grid_lookup_unit_tb: errors");
    end
    $finish;
  end

endmodule
